@@ design/stmh_pkg.sv @@
// Shared types, constants and helper functions of the sliding-tile heuristic core.
// No dependencies; the other design files but the checker refer to it by scoped names.

package stmh_pkg;

    // Board and field sizes.
    localparam int MAX_TILES = 16;
    localparam int TILE_W    = 4;
    localparam int IDX_W     = 4;                      // nibble index into the goal word
    localparam int POS_W     = $clog2(MAX_TILES + 1);  // position counter, holds MAX_TILES
    localparam int COLS_W    = 3;
    localparam int COL_W     = 2;
    localparam int GROW_W    = 3;                      // goal row, at most 7
    localparam int ROW_W     = 4;                      // running row, may pass 7
    localparam int DIST_W    = 4;                      // one tile's distance, at most 11
    localparam int SUM_W     = 7;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 64;
    localparam int GOAL_W = 64;

    localparam logic [1:0] REG_COLUMNS        = 2'd0;
    localparam logic [1:0] REG_GOAL_ORDER     = 2'd1;
    localparam logic [1:0] REG_MANHATTAN_MODE = 2'd2;

    localparam logic [COLS_W-1:0] COLUMNS_RST = 3'd4;
    localparam logic [GOAL_W-1:0] GOAL_RST    = 64'hFEDC_BA98_7654_3210;
    localparam logic              MODE_RST    = 1'b1;

    typedef struct packed {
        logic [COLS_W-1:0] columns;
        logic [GOAL_W-1:0] goal_order;
        logic              manhattan_mode;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [GROW_W-1:0] row;
    } coord_t;

    // Column count clamped to the supported range of two to four.
    function automatic logic [COLS_W-1:0] eff_columns(input logic [COLS_W-1:0] cols);
        logic [COLS_W-1:0] c;
        c = cols;
        if (c < 3'd2)
        begin
            c = 3'd2;
        end
        else if (c > 3'd4)
        begin
            c = 3'd4;
        end
        return c;
    endfunction

    // Row and column of a goal position for a clamped column count.
    // Division by three uses the reciprocal 11/32, exact for indexes below 16.
    function automatic coord_t goal_coord(input logic [IDX_W-1:0] idx,
                                          input logic [COLS_W-1:0] cols);
        coord_t     c;
        logic [7:0] prod;
        logic [3:0] rem;
        prod = 8'({4'b0, idx} * 8'd11);
        rem  = 4'd0;
        unique case (cols)
            3'd2:
            begin
                c.col = {1'b0, idx[0]};
                c.row = idx[3:1];
            end
            3'd3:
            begin
                c.row = prod[7:5];
                rem   = idx - {c.row, 1'b0} - {1'b0, c.row};
                c.col = rem[1:0];
            end
            default:
            begin
                c.col = idx[1:0];
                c.row = {1'b0, idx[3:2]};
            end
        endcase
        return c;
    endfunction

endpackage

@@ design/stmh_cfg_regs.sv @@
// Configuration register file of the sliding-tile heuristic core, APB-style slave.
// Depends on stmh_pkg for the register map, reset values and the cfg_t struct.

module stmh_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stmh_pkg::APB_AW-1:0] paddr,
    input  logic [stmh_pkg::APB_DW-1:0] pwdata,
    output logic [stmh_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output stmh_pkg::cfg_t              cfg
);

    logic [stmh_pkg::COLS_W-1:0] columns_reg;
    logic [stmh_pkg::GOAL_W-1:0] goal_reg;
    logic                        mode_reg;
    logic                        wr_en;
    logic [1:0]                  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= stmh_pkg::COLUMNS_RST;
            goal_reg    <= stmh_pkg::GOAL_RST;
            mode_reg    <= stmh_pkg::MODE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                stmh_pkg::REG_COLUMNS:        columns_reg <= pwdata[stmh_pkg::COLS_W-1:0];
                stmh_pkg::REG_GOAL_ORDER:     goal_reg    <= pwdata[stmh_pkg::GOAL_W-1:0];
                stmh_pkg::REG_MANHATTAN_MODE: mode_reg    <= pwdata[0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            stmh_pkg::REG_COLUMNS:
                prdata = {{(stmh_pkg::APB_DW-stmh_pkg::COLS_W){1'b0}}, columns_reg};
            stmh_pkg::REG_GOAL_ORDER:
                prdata = goal_reg;
            stmh_pkg::REG_MANHATTAN_MODE:
                prdata = {{(stmh_pkg::APB_DW-1){1'b0}}, mode_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.columns        = columns_reg;
    assign cfg.goal_order     = goal_reg;
    assign cfg.manhattan_mode = mode_reg;

endmodule

@@ design/stmh_goal_lookup.sv @@
// Goal lookup and single-tile Manhattan distance of the sliding-tile heuristic core.
// Depends on stmh_pkg for widths and the goal coordinate function.

module stmh_goal_lookup
(
    input  logic [stmh_pkg::TILE_W-1:0] tile,
    input  logic [stmh_pkg::GOAL_W-1:0] goal_order,
    input  logic [stmh_pkg::COLS_W-1:0] cols,
    input  logic [stmh_pkg::COL_W-1:0]  column_now,
    input  logic [stmh_pkg::ROW_W-1:0]  row_now,
    output logic [stmh_pkg::DIST_W-1:0] tile_dist
);

    logic                        found;
    logic [stmh_pkg::IDX_W-1:0]  sel;
    stmh_pkg::coord_t            gc;
    logic [stmh_pkg::COL_W-1:0]  dcol;
    logic [stmh_pkg::ROW_W-1:0]  grow;
    logic [stmh_pkg::ROW_W-1:0]  drow;

    // Lowest goal position holding the tile wins; scanning downward lets it overwrite.
    always_comb
    begin
        found = 1'b0;
        sel   = '0;
        for (int i = stmh_pkg::MAX_TILES - 1; i >= 0; i--)
        begin
            if (goal_order[i*stmh_pkg::TILE_W +: stmh_pkg::TILE_W] == tile)
            begin
                found = 1'b1;
                sel   = stmh_pkg::IDX_W'(i);
            end
        end
    end

    assign gc   = stmh_pkg::goal_coord(sel, cols);
    assign grow = {1'b0, gc.row};
    assign dcol = (gc.col > column_now) ? gc.col - column_now : column_now - gc.col;
    assign drow = (grow > row_now) ? grow - row_now : row_now - grow;

    // The blank and tiles missing from the goal contribute nothing.
    assign tile_dist = (found && (tile != '0)) ? ({2'b0, dcol} + drow) : '0;

endmodule

@@ design/sliding_tile_manhattan_heuristic_core.sv @@
// Top level of the sliding-tile Manhattan heuristic core.
// Depends on stmh_pkg, stmh_cfg_regs and stmh_goal_lookup.
//
// Usage: a board arrives on the s_axis request channel one tile per request,
// in position order (row by row, left to right), with s_axis_tlast set on the
// final position. For each non-blank tile the core finds the tile's position
// in the configured goal board and adds the row and column distance to a
// running sum. The request carrying tlast produces one result on m_axis: the
// saturated distance sum, or, with manhattan_mode at 0, 0 when the board
// matched the goal at every position and 1 otherwise.
// Registers: columns, goal_order and manhattan_mode sit on the APB-style port
// at byte addresses 0, 8 and 16; write them only between boards.
// Pipeline: a request is held in an input register, then the lookup and
// accumulate step writes the result register, from which the result is
// offered on m_axis. Throughput is one tile per cycle while no last tile
// waits on a result that is not yet taken.
// Stalls: while a result waits on m_axis the core keeps taking non-last tiles;
// only a second last tile is held in the input register, deasserting
// s_axis_tready, until the waiting result is taken.
// Reset clears all board state and loads the default goal 0..15 in order,
// four columns and Manhattan mode.

module sliding_tile_manhattan_heuristic_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stmh_pkg::APB_AW-1:0] paddr,
    input  logic [stmh_pkg::APB_DW-1:0] pwdata,
    output logic [stmh_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    // Tile input.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [3:0] tile, [7:4] zero
    input  logic                        s_axis_tlast,   // final position of the board
    // Heuristic output.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata    // [6:0] heuristic, [7] zero
);

    stmh_pkg::cfg_t cfg;

    stmh_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register.
    logic                        in_vld_reg;
    logic [stmh_pkg::TILE_W-1:0] in_tile_reg;
    logic                        in_last_reg;

    // Board state.
    logic [stmh_pkg::POS_W-1:0]  position_reg, position_next;
    logic [stmh_pkg::COL_W-1:0]  column_reg, column_next;
    logic [stmh_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [stmh_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic                        match_reg, match_next;

    // Result register.
    logic                        out_vld_reg;
    logic [stmh_pkg::SUM_W-1:0]  out_heur_reg;

    logic                        advance;
    logic                        pos_live;
    logic [stmh_pkg::COLS_W-1:0] cols;
    logic [stmh_pkg::DIST_W-1:0] tile_dist;
    logic [stmh_pkg::SUM_W:0]    sum_wide;
    logic [stmh_pkg::SUM_W-1:0]  sum_upd;
    logic                        match_upd;
    logic [stmh_pkg::TILE_W-1:0] goal_here;
    logic [stmh_pkg::COLS_W-1:0] col_inc;
    logic [stmh_pkg::SUM_W-1:0]  heur;

    // A non-last tile never needs the result register; a last one needs it empty or being taken.
    assign advance       = in_vld_reg && (!in_last_reg || !out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_tile_reg <= s_axis_tdata[stmh_pkg::TILE_W-1:0];
            in_last_reg <= s_axis_tlast;
        end
    end

    assign cols = stmh_pkg::eff_columns(cfg.columns);

    stmh_goal_lookup u_lookup
    (
        .tile       (in_tile_reg),
        .goal_order (cfg.goal_order),
        .cols       (cols),
        .column_now (column_reg),
        .row_now    (row_reg),
        .tile_dist  (tile_dist)
    );

    // Positions past the board size are ignored apart from the last mark.
    assign pos_live  = position_reg < stmh_pkg::POS_W'(stmh_pkg::MAX_TILES);
    assign goal_here = cfg.goal_order[position_reg[stmh_pkg::IDX_W-1:0]*stmh_pkg::TILE_W
                                      +: stmh_pkg::TILE_W];
    assign sum_wide  = {1'b0, sum_reg}
                     + {{(stmh_pkg::SUM_W+1-stmh_pkg::DIST_W){1'b0}}, tile_dist};
    assign sum_upd   = !pos_live ? sum_reg
                     : (sum_wide[stmh_pkg::SUM_W] ? stmh_pkg::SUM_MAX
                                                  : sum_wide[stmh_pkg::SUM_W-1:0]);
    assign match_upd = match_reg && (!pos_live || (in_tile_reg == goal_here));
    assign col_inc   = {1'b0, column_reg} + 3'd1;
    assign heur      = cfg.manhattan_mode ? sum_upd
                                          : {{(stmh_pkg::SUM_W-1){1'b0}}, !match_upd};

    always_comb
    begin
        position_next = position_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        sum_next      = sum_reg;
        match_next    = match_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                position_next = '0;
                column_next   = '0;
                row_next      = '0;
                sum_next      = '0;
                match_next    = 1'b1;
            end
            else
            begin
                sum_next   = sum_upd;
                match_next = match_upd;
                if (pos_live)
                begin
                    position_next = position_reg + 1'b1;
                    // The column counter wraps against the current column count.
                    if (col_inc >= cols)
                    begin
                        column_next = '0;
                        row_next    = row_reg + 1'b1;
                    end
                    else
                    begin
                        column_next = col_inc[stmh_pkg::COL_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            column_reg   <= '0;
            row_reg      <= '0;
            sum_reg      <= '0;
            match_reg    <= 1'b1;
        end
        else
        begin
            position_reg <= position_next;
            column_reg   <= column_next;
            row_reg      <= row_next;
            sum_reg      <= sum_next;
            match_reg    <= match_next;
        end
    end

    // Result register: loaded by a last tile, emptied when the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_heur_reg <= heur;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {1'b0, out_heur_reg};

endmodule

@@ design/stmh_checker.sv @@
// Port-level assertions for the sliding-tile heuristic core, bound to its top level.
// Depends only on the top-level port names.

module stmh_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // The input side stalls only while a result is waiting and blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the result register could take a request");

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("waiting result changed or vanished");

    // The heuristic never exceeds its seven bits; the pad bit stays clear.
    a_pad_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("result pad bit set");

    // No result is offered and the input is not stalled as reset is released.
    a_no_result_at_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> (!m_axis_tvalid && s_axis_tready))
        else $error("result or stall present right after reset");

endmodule

bind sliding_tile_manhattan_heuristic_core stmh_checker u_stmh_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb.sv @@
// Self-checking testbench for the sliding-tile Manhattan heuristic core.
// Needs stmh_pkg and the core's RTL; it predicts every heuristic itself and
// compares it with what the core returns on m_axis.

`timescale 1ns / 1ps

module tb;

    // Column counts used by the first random phases, lowest slot first:
    // every supported count and every out-of-range code that has to be clamped.
    localparam logic [29:0] COL_PLAN = {3'd6, 3'd5, 3'd1, 3'd4, 3'd2,
                                        3'd7, 3'd0, 3'd3, 3'd2, 3'd4};
    localparam int TARGET_ITEMS = 850;
    localparam int PRESSURE_PHASE = 4;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [3:0] tile;
        logic       last;
    } tile_req_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [stmh_pkg::APB_AW-1:0] paddr = '0;
    logic [stmh_pkg::APB_DW-1:0] pwdata = '0;
    logic [stmh_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [3:0] tile, [7:4] zero
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;        // [6:0] heuristic, [7] zero

    // Tile requests waiting to be offered, and heuristics still owed by the core.
    tile_req_t         pending [$];
    logic [6:0]        heuristic_due [$];
    int                items_queued = 0;
    int                mismatches = 0;
    int                cycles = 0;

    // Our copy of the configuration registers, updated as each write lands.
    logic [2:0]        columns_reg = stmh_pkg::COLUMNS_RST;
    logic [63:0]       goal_word = stmh_pkg::GOAL_RST;
    logic              mode_reg = stmh_pkg::MODE_RST;

    // Board being accumulated: position, running column and row, distance
    // sum, and whether every tile so far matched the goal.
    int                board_pos = 0;
    int                board_col = 0;
    int                board_row = 0;
    int                board_dist = 0;
    bit                board_match = 1'b1;

    // Idle control. A calm flag turns that side's random waits off for a phase.
    bit                tx_calm = 1'b0;
    bit                rx_calm = 1'b0;
    int                tx_gap = 0;
    int                rx_gap = 0;
    int                rx_wait;
    tile_req_t         next_req;

    // One long receiver hold-off, counted down in its own process.
    logic              stall_go = 1'b0;
    int                stall_left = 400;
    wire               rx_hold = stall_go && (stall_left != 0);

    sliding_tile_manhattan_heuristic_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
    endtask

    // Advance the board state by one accepted tile. A tile at position 16 or
    // later is ignored apart from its last mark. The goal position of a tile
    // is the lowest nibble holding it; a tile the goal lacks adds nothing.
    task automatic score_tile(input logic [3:0] tile, input logic last);
        int cols;
        int gi;
        int gcol;
        int grow;
        int d;
        bit hit;
        cols = (columns_reg < 3'd2) ? 2 : (columns_reg > 3'd4) ? 4 : int'(columns_reg);
        hit = 1'b0;
        if (board_pos < stmh_pkg::MAX_TILES)
        begin
            if (tile != goal_word[4*board_pos +: 4])
                board_match = 1'b0;
            if (tile != 4'd0)
            begin
                for (gi = 0; gi < stmh_pkg::MAX_TILES; gi++)
                begin
                    if (!hit && goal_word[4*gi +: 4] == tile)
                    begin
                        hit  = 1'b1;
                        gcol = gi % cols;
                        grow = gi / cols;
                        d = (gcol > board_col) ? gcol - board_col : board_col - gcol;
                        d += (grow > board_row) ? grow - board_row : board_row - grow;
                        // The sum saturates instead of wrapping.
                        board_dist = (board_dist + d > int'(stmh_pkg::SUM_MAX))
                                   ? int'(stmh_pkg::SUM_MAX) : board_dist + d;
                    end
                end
            end
            board_pos++;
            // The column counter wraps against the column count in force now.
            if (board_col + 1 >= cols)
            begin
                board_col = 0;
                board_row++;
            end
            else
            begin
                board_col++;
            end
        end
        if (last)
        begin
            // The mode in force on the last tile picks the kind of result.
            if (mode_reg)
                heuristic_due = {heuristic_due, 7'(board_dist)};
            else
                heuristic_due = {heuristic_due, (board_match ? 7'd0 : 7'd1)};
            board_pos   = 0;
            board_col   = 0;
            board_row   = 0;
            board_dist  = 0;
            board_match = 1'b1;
        end
    endtask

    // Random permutation of the sixteen nibbles of a word.
    function automatic logic [63:0] shuffle_nibbles(input logic [63:0] word);
        logic [63:0] w;
        logic [3:0]  t;
        int          k;
        int          j;
        w = word;
        for (k = 15; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = w[4*k +: 4];
            w[4*k +: 4] = w[4*j +: 4];
            w[4*j +: 4] = t;
        end
        return w;
    endfunction

    task automatic push_tile(input logic [3:0] tile, input logic last);
        tile_req_t r;
        r.tile = tile;
        r.last = last;
        pending = {pending, r};
        items_queued++;
    endtask

    // Queue one board. Most boards are the goal itself, a prefix of it with or
    // without one swap, or a scramble of the goal tiles; the rest are random
    // tiles, some running past sixteen positions. Without close the board is
    // left open, so the next configuration lands in the middle of it.
    task automatic queue_board(input bit close, input int cap);
        logic [63:0] src;
        logic [3:0]  tiles [$];
        logic [3:0]  t;
        int          len;
        int          kind;
        int          k;
        int          a;
        int          b;
        kind = $urandom_range(0, 9);
        src  = goal_word;
        if (kind >= 3 && kind < 7)
            src = shuffle_nibbles(goal_word);
        len = (kind < 7 && $urandom_range(0, 2) != 0) ? 16 : $urandom_range(1, 16);
        if (kind == 9)
            len = $urandom_range(17, 22);
        if (len > cap)
            len = $urandom_range(1, cap);
        for (k = 0; k < len; k++)
        begin
            if (kind < 7)
                tiles = {tiles, src[4*(k % 16) +: 4]};
            else
                tiles = {tiles, 4'($urandom_range(0, 15))};
        end
        if (kind < 3 && len > 1 && $urandom_range(0, 1) == 1)
        begin
            a = $urandom_range(0, len - 1);
            b = $urandom_range(0, len - 1);
            t = tiles[a];
            tiles[a] = tiles[b];
            tiles[b] = t;
        end
        for (k = 0; k < len; k++)
            push_tile(tiles[k], close && (k == len - 1));
    endtask

    // APB write of one register followed by a read-back of it. Our copy of the
    // register changes at the edge where the core takes the write.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        logic [63:0] mask;
        mask = (idx == stmh_pkg::REG_COLUMNS) ? 64'h7 :
               (idx == stmh_pkg::REG_MANHATTAN_MODE) ? 64'h1 : {64{1'b1}};
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            stmh_pkg::REG_COLUMNS:        columns_reg = value[2:0];
            stmh_pkg::REG_GOAL_ORDER:     goal_word = value;
            stmh_pkg::REG_MANHATTAN_MODE: mode_reg = value[0];
            default:                      ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (value & mask))
            note_failure($sformatf("register %0d reads %0h, expected %0h",
                                   idx, prdata & mask, value & mask));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every request is taken and every heuristic has come back,
    // then give the core's two-stage pipeline time to absorb open-board tiles.
    task automatic settle;
        @(negedge clk);
        while (pending.size() != 0 || s_axis_tvalid || heuristic_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Tile driver: holds a request until it is taken, waits its drawn gap,
    // then offers the next one from the pending queue. Every accepted request
    // is fed to the predictor at the edge it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            tx_gap        <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                score_tile(s_axis_tdata[3:0], s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    next_req = pending.pop_front();
                    s_axis_tdata  <= {4'b0000, next_req.tile};
                    s_axis_tlast  <= next_req.last;
                    s_axis_tvalid <= 1'b1;
                    tx_gap        <= tx_calm ? 0 : $urandom_range(0, 4);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted heuristic against the oldest one
    // owed. After each result it draws a wait that runs while a result is
    // offered; the long hold-off overrides everything.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap        <= 0;
        end
        else
        begin
            rx_wait = rx_gap;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (heuristic_due.size() == 0)
                    note_failure($sformatf("heuristic %0d with none expected",
                                           m_axis_tdata));
                else if (m_axis_tdata !== {1'b0, heuristic_due[0]})
                    note_failure($sformatf("heuristic %0d, expected %0d",
                                           m_axis_tdata, heuristic_due[0]));
                if (heuristic_due.size() != 0)
                    void'(heuristic_due.pop_front());
                rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
            end
            if (rx_hold)
            begin
                m_axis_tready <= 1'b0;
                rx_gap        <= rx_wait;
            end
            else if (rx_wait != 0)
            begin
                m_axis_tready <= 1'b0;
                rx_gap        <= m_axis_tvalid ? rx_wait - 1 : rx_wait;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                rx_gap        <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_go && stall_left != 0)
            stall_left <= stall_left - 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          start;
        int          k;
        int          pick;
        logic [2:0]  cols_pick;
        logic [63:0] goal_pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: goal 0..15 on four columns, distance mode.
        // Single-tile boards at both tile extremes, a blank, and a mixed board.
        push_tile(4'd15, 1'b1);
        push_tile(4'd0, 1'b1);
        push_tile(4'd5, 1'b0);
        push_tile(4'd0, 1'b0);
        push_tile(4'd15, 1'b0);
        push_tile(4'd10, 1'b1);
        settle();

        // Goal-mismatch mode: the blank compares like any tile, a matching
        // prefix reports 0, one swap reports 1.
        write_reg(stmh_pkg::REG_MANHATTAN_MODE, 64'd0);
        push_tile(4'd0, 1'b1);
        push_tile(4'd15, 1'b1);
        for (k = 0; k < 4; k++)
            push_tile(4'(k), k == 3);
        push_tile(4'd0, 1'b0);
        push_tile(4'd1, 1'b0);
        push_tile(4'd3, 1'b0);
        push_tile(4'd2, 1'b1);
        settle();

        // Open a board on two columns in distance mode, then change both the
        // column count and the mode before it closes.
        write_reg(stmh_pkg::REG_COLUMNS, 64'd2);
        write_reg(stmh_pkg::REG_MANHATTAN_MODE, 64'd1);
        push_tile(4'd3, 1'b0);
        push_tile(4'd2, 1'b0);
        settle();
        write_reg(stmh_pkg::REG_COLUMNS, 64'd3);
        write_reg(stmh_pkg::REG_MANHATTAN_MODE, 64'd0);
        push_tile(4'd1, 1'b0);
        push_tile(4'd0, 1'b0);
        push_tile(4'd15, 1'b1);
        settle();

        // Random phases, each with its own configuration and idle behavior.
        phase = 0;
        while (items_queued < TARGET_ITEMS)
        begin
            cols_pick = (phase < 10) ? COL_PLAN[3*phase +: 3] : 3'($urandom_range(0, 7));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                goal_pick = shuffle_nibbles(stmh_pkg::GOAL_RST);
            else if (pick < 9)
                goal_pick = {$urandom, $urandom};
            else
                goal_pick = ($urandom_range(0, 2) == 0) ? 64'd0 :
                            ($urandom_range(0, 1) == 0) ? {64{1'b1}} : stmh_pkg::GOAL_RST;
            write_reg(stmh_pkg::REG_COLUMNS, 64'(cols_pick));
            write_reg(stmh_pkg::REG_GOAL_ORDER, goal_pick);
            write_reg(stmh_pkg::REG_MANHATTAN_MODE, 64'($urandom_range(0, 2) != 0));
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);

            if (phase == PRESSURE_PHASE)
            begin
                // Short boards at full rate while the receiver holds off, so
                // a waiting result backs the core up and it stalls its input.
                tx_calm = 1'b1;
                stall_go <= 1'b1;
                for (k = 0; k < 40; k++)
                    queue_board(1'b1, 3);
            end
            else
            begin
                start = items_queued;
                while (items_queued - start < 60)
                    queue_board(1'b1, 22);
                if (phase % 3 == 1)
                    queue_board(1'b0, 22);
            end
            settle();
            phase++;
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sliding_tile_manhattan_heuristic_core.f @@
design/stmh_pkg.sv
design/stmh_cfg_regs.sv
design/stmh_goal_lookup.sv
design/sliding_tile_manhattan_heuristic_core.sv
design/stmh_checker.sv
tb/tb.sv
